// ===== hdl/lhwt_pkg.sv =====
// ----------------------------------------------------------------------------
// lhwt_pkg
// Shared types and constants for the link heartbeat watchdog table.
// ----------------------------------------------------------------------------
package lhwt_pkg;

    localparam int LHWT_ENTRIES = 256;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_HEARTBEAT = 3'd1;
    localparam logic [2:0] OP_SET_CONN  = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_LOAD_VLD  = 3'd4;

    localparam logic [1:0] REG_COUNTDOWN_RELOAD = 2'd0;
    localparam logic [1:0] REG_MISS_LIMIT       = 2'd1;
    localparam logic [1:0] REG_BEACON_PERIOD    = 2'd2;

    localparam logic [7:0] RST_COUNTDOWN_RELOAD = 8'h14;
    localparam logic [7:0] RST_MISS_LIMIT       = 8'h14;
    localparam logic [3:0] RST_BEACON_PERIOD    = 4'd5;

    localparam logic [7:0] MISS_MAX = 8'hff;
    localparam logic [8:0] DROP_MAX = 9'h1ff;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] entry_index;
        logic       flag_value;
    } cmd_t;

    typedef struct packed {
        logic       send_beacon;
        logic [8:0] dropped_count;
        logic       is_connected;
        logic       index_error;
    } result_t;

    typedef struct packed {
        logic [7:0] countdown_reload;
        logic [7:0] miss_limit;
        logic [3:0] beacon_period;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       connected;
        logic [7:0] countdown;
        logic [7:0] misses;
    } entry_t;

endpackage

// ===== hdl/link_heartbeat_watchdog_table.sv =====
// ----------------------------------------------------------------------------
// link_heartbeat_watchdog_table
// Heartbeat watchdog over a table of link entries held in one RAM.
//
//   channel   signals                                    transfer
//   command   start, busy, cmd                           start && !busy
//   result    done, result                               done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// Tick: busy while every entry is read-modify-written, one entry per cycle,
// through the table RAM; result in the cycle after the last. Ops 1 to 4: busy
// (read at transfer, write back next); a bad index answers the next cycle.
// After reset a clearing pass over every entry holds busy high.
// The result strobe cannot be stalled; a new command may be taken
// in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module link_heartbeat_watchdog_table #(
    parameter int ENTRIES = lhwt_pkg::LHWT_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lhwt_pkg::cmd_t    cmd,
    output logic              done,
    output lhwt_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_RMW   = 2'd3;

    lhwt_pkg::cfg_t    cfg;
    lhwt_pkg::entry_t  rd_data;
    lhwt_pkg::entry_t  wr_data;
    lhwt_pkg::entry_t  upd;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     rd_addr;

    logic [1:0]        state_reg, state_next;
    logic [IW-1:0]     ptr_reg, ptr_next;
    logic [2:0]        op_reg, op_next;
    logic              flag_reg, flag_next;
    logic              db_reg, db_next;
    logic [3:0]        ticks_reg, ticks_next;
    logic              beacon_reg, beacon_next;
    logic [8:0]        drop_reg, drop_next;
    logic              done_reg, done_next;
    lhwt_pkg::result_t result_reg, result_next;

    logic              accept;
    logic              in_range;
    logic [4:0]        tick_sum;
    logic [7:0]        cd_dec;
    logic [7:0]        miss_inc;
    logic              drop;
    logic              ok;

    lhwt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lhwt_ram #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(cmd.entry_index) < ENTRIES);
    assign tick_sum = {1'b0, ticks_reg} + 5'd1;

    // per-entry tick update
    always_comb
    begin
        upd      = rd_data;
        drop     = 1'b0;
        cd_dec   = rd_data.countdown - 8'd1;
        miss_inc = (rd_data.misses != lhwt_pkg::MISS_MAX) ? rd_data.misses + 8'd1
                                                          : rd_data.misses;
        if (rd_data.valid && rd_data.connected)
        begin
            upd.countdown = cd_dec;
            if (cd_dec == 8'd0)
            begin
                upd.countdown = cfg.countdown_reload;
                if (miss_inc > cfg.miss_limit)
                begin
                    drop          = 1'b1;
                    upd.connected = 1'b0;
                    upd.misses    = 8'd0;
                end
                else
                begin
                    upd.misses = miss_inc;
                end
            end
        end
    end

    assign ok = db_reg || rd_data.valid;

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        op_next     = op_reg;
        flag_next   = flag_reg;
        db_next     = db_reg;
        ticks_next  = ticks_reg;
        beacon_next = beacon_reg;
        drop_next   = drop_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = rd_data;
        rd_addr     = ptr_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en             = 1'b1;
                wr_data.valid     = 1'b0;
                wr_data.connected = 1'b0;
                wr_data.countdown = lhwt_pkg::RST_COUNTDOWN_RELOAD;
                wr_data.misses    = 8'd0;
                ptr_next          = IW'(ptr_reg + 1'b1);
                if (ptr_reg == LAST)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                rd_addr = IW'(cmd.entry_index);
                if (accept)
                begin
                    op_next   = cmd.opcode;
                    flag_next = cmd.flag_value;
                    db_next   = (32'(cmd.entry_index) == ENTRIES - 1);
                    if (cmd.opcode == lhwt_pkg::OP_TICK)
                    begin
                        rd_addr   = '0;
                        ptr_next  = '0;
                        drop_next = 9'd0;
                        if (tick_sum >= {1'b0, cfg.beacon_period})
                        begin
                            beacon_next = 1'b1;
                            ticks_next  = 4'd0;
                        end
                        else
                        begin
                            beacon_next = 1'b0;
                            ticks_next  = tick_sum[3:0];
                        end
                        state_next = ST_SWEEP;
                    end
                    else if (cmd.opcode <= lhwt_pkg::OP_LOAD_VLD && in_range)
                    begin
                        ptr_next   = IW'(cmd.entry_index);
                        state_next = ST_RMW;
                    end
                    else
                    begin
                        done_next               = 1'b1;
                        result_next             = '0;
                        result_next.index_error = (cmd.opcode != lhwt_pkg::OP_LOAD_VLD)
                                                  && (cmd.opcode <= lhwt_pkg::OP_QUERY);
                    end
                end
            end
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_data = upd;
                rd_addr = IW'(ptr_reg + 1'b1);
                if (drop && drop_reg != lhwt_pkg::DROP_MAX)
                begin
                    drop_next = drop_reg + 9'd1;
                end
                ptr_next = IW'(ptr_reg + 1'b1);
                if (ptr_reg == LAST)
                begin
                    state_next                = ST_IDLE;
                    done_next                 = 1'b1;
                    result_next               = '0;
                    result_next.send_beacon   = beacon_reg;
                    result_next.dropped_count = drop_next;
                end
            end
            ST_RMW:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = '0;
                case (op_reg)
                    lhwt_pkg::OP_HEARTBEAT:
                    begin
                        wr_en             = ok;
                        wr_data.countdown = cfg.countdown_reload;
                        wr_data.misses    = 8'd0;
                    end
                    lhwt_pkg::OP_SET_CONN:
                    begin
                        wr_en             = ok;
                        wr_data.connected = flag_reg;
                    end
                    lhwt_pkg::OP_QUERY:
                    begin
                        result_next.is_connected = ok && rd_data.connected;
                    end
                    default:
                    begin
                        wr_en         = 1'b1;
                        wr_data.valid = flag_reg;
                    end
                endcase
                result_next.index_error = !ok && (op_reg != lhwt_pkg::OP_LOAD_VLD);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ptr_reg    <= '0;
            op_reg     <= lhwt_pkg::OP_TICK;
            ticks_reg  <= 4'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            op_reg     <= op_next;
            ticks_reg  <= ticks_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg   <= flag_next;
        db_reg     <= db_next;
        beacon_reg <= beacon_next;
        drop_reg   <= drop_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_sweep_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (wr_addr != rd_addr))
        else $error("sweep read and write hit the same entry");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done))
        else $error("accepted command neither busy nor answered");

    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (op_reg == lhwt_pkg::OP_TICK
                  || (result.dropped_count == 9'd0 && !result.send_beacon)))
        else $error("tick fields set on a non-tick result");
`endif

endmodule

// ===== hdl/lhwt_ram.sv =====
// ----------------------------------------------------------------------------
// lhwt_ram
// Entry table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lhwt_ram #(
    parameter int ENTRIES = lhwt_pkg::LHWT_ENTRIES,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_addr,
    input  lhwt_pkg::entry_t wr_data,
    input  logic [IW-1:0]    rd_addr,
    output lhwt_pkg::entry_t rd_data
);

    lhwt_pkg::entry_t mem [ENTRIES];
    lhwt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lhwt_cfg.sv =====
// ----------------------------------------------------------------------------
// lhwt_cfg
// Configuration registers: countdown reload, miss limit, beacon period.
// ----------------------------------------------------------------------------
module lhwt_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    output lhwt_pkg::cfg_t cfg
);

    lhwt_pkg::cfg_t cfg_reg;
    lhwt_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lhwt_pkg::REG_COUNTDOWN_RELOAD: cfg_next.countdown_reload = cfg_data;
                lhwt_pkg::REG_MISS_LIMIT:       cfg_next.miss_limit       = cfg_data;
                lhwt_pkg::REG_BEACON_PERIOD:    cfg_next.beacon_period    = cfg_data[3:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.countdown_reload <= lhwt_pkg::RST_COUNTDOWN_RELOAD;
            cfg_reg.miss_limit       <= lhwt_pkg::RST_MISS_LIMIT;
            cfg_reg.beacon_period    <= lhwt_pkg::RST_BEACON_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for link_heartbeat_watchdog_table. A shadow copy of the
// entry table and registers predicts the status of every command. A short
// table of directed commands runs first. Phases with different register
// settings follow, each bringing up a window of links and then issuing
// random commands. Every status strobe is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         DB_INDEX    = lhwt_pkg::LHWT_ENTRIES - 1;
    localparam int         CYCLE_LIMIT = 1_600_000;

    typedef struct packed {
        lhwt_pkg::cmd_t    c;
        logic              typed;
        lhwt_pkg::result_t want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    lhwt_pkg::cmd_t    cmd_bus = '0;
    logic              done;
    lhwt_pkg::result_t result_bus;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [7:0]        cfg_data = '0;

    // shadow table and registers
    logic       tbl_valid [lhwt_pkg::LHWT_ENTRIES];
    logic       tbl_conn  [lhwt_pkg::LHWT_ENTRIES];
    logic [7:0] tbl_count [lhwt_pkg::LHWT_ENTRIES];
    logic [7:0] tbl_miss  [lhwt_pkg::LHWT_ENTRIES];
    logic [3:0] beacon_cnt;
    lhwt_pkg::cfg_t shadow_cfg;

    lhwt_pkg::result_t owed_status [$];
    lhwt_pkg::result_t oldest;
    int         mismatches = 0;
    int         cycles = 0;
    bit         burst = 1'b0;
    dir_row_t   directed [$];

    link_heartbeat_watchdog_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd_bus),
        .done      (done),
        .result    (result_bus),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic lhwt_pkg::result_t apply_command(input lhwt_pkg::cmd_t c);
        lhwt_pkg::result_t r;
        logic [4:0] next_ticks;
        logic       ok;
        int         i;
        int         idx;
        r = '0;
        idx = int'(c.entry_index);
        case (c.opcode)
            lhwt_pkg::OP_TICK:
            begin
                next_ticks = {1'b0, beacon_cnt} + 5'd1;
                if (next_ticks >= {1'b0, shadow_cfg.beacon_period})
                begin
                    r.send_beacon = 1'b1;
                    beacon_cnt = '0;
                end
                else
                    beacon_cnt = next_ticks[3:0];
                for (i = 0; i < lhwt_pkg::LHWT_ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_conn[i])
                    begin
                        tbl_count[i] = tbl_count[i] - 8'd1;
                        if (tbl_count[i] == 8'd0)
                        begin
                            if (tbl_miss[i] != lhwt_pkg::MISS_MAX)
                                tbl_miss[i] = tbl_miss[i] + 8'd1;
                            if (tbl_miss[i] > shadow_cfg.miss_limit)
                            begin
                                tbl_conn[i]  = 1'b0;
                                tbl_count[i] = shadow_cfg.countdown_reload;
                                tbl_miss[i]  = '0;
                                if (r.dropped_count != lhwt_pkg::DROP_MAX)
                                    r.dropped_count = r.dropped_count + 9'd1;
                            end
                            else
                                tbl_count[i] = shadow_cfg.countdown_reload;
                        end
                    end
                end
            end
            lhwt_pkg::OP_HEARTBEAT, lhwt_pkg::OP_SET_CONN, lhwt_pkg::OP_QUERY:
            begin
                ok = (idx < lhwt_pkg::LHWT_ENTRIES) && (idx == DB_INDEX || tbl_valid[idx]);
                if (!ok)
                    r.index_error = 1'b1;
                else if (c.opcode == lhwt_pkg::OP_HEARTBEAT)
                begin
                    tbl_count[idx] = shadow_cfg.countdown_reload;
                    tbl_miss[idx]  = '0;
                end
                else if (c.opcode == lhwt_pkg::OP_SET_CONN)
                    tbl_conn[idx] = c.flag_value;
                else
                    r.is_connected = tbl_conn[idx];
            end
            lhwt_pkg::OP_LOAD_VLD:
            begin
                if (idx < lhwt_pkg::LHWT_ENTRIES)
                    tbl_valid[idx] = c.flag_value;
            end
            default: ;
        endcase
        return r;
    endfunction

    // status check, oldest expectation first
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (owed_status.size() == 0)
                flag_mismatch("status with nothing owed", int'(result_bus), 0);
            else
            begin
                oldest = owed_status.pop_front();
                if (result_bus.send_beacon !== oldest.send_beacon)
                    flag_mismatch("send_beacon", result_bus.send_beacon, oldest.send_beacon);
                if (result_bus.dropped_count !== oldest.dropped_count)
                    flag_mismatch("dropped_count", result_bus.dropped_count,
                                  oldest.dropped_count);
                if (result_bus.is_connected !== oldest.is_connected)
                    flag_mismatch("is_connected", result_bus.is_connected, oldest.is_connected);
                if (result_bus.index_error !== oldest.index_error)
                    flag_mismatch("index_error", result_bus.index_error, oldest.index_error);
            end
        end
    end

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_cmd(input lhwt_pkg::cmd_t c, input logic typed,
                            input lhwt_pkg::result_t want);
        lhwt_pkg::result_t got;
        int      gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        cmd_bus <= c;
        do @(posedge clk); while (busy);
        got = apply_command(c);
        owed_status.push_back(typed ? want : got);
    endtask

    task automatic send_op(input logic [2:0] op, input int idx, input logic flag);
        lhwt_pkg::cmd_t c;
        c.opcode      = op;
        c.entry_index = idx[7:0];
        c.flag_value  = flag;
        send_cmd(c, 1'b0, '0);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (owed_status.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            lhwt_pkg::REG_COUNTDOWN_RELOAD: shadow_cfg.countdown_reload = data;
            lhwt_pkg::REG_MISS_LIMIT:       shadow_cfg.miss_limit = data;
            lhwt_pkg::REG_BEACON_PERIOD:    shadow_cfg.beacon_period = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic lhwt_pkg::cmd_t random_cmd(input int tick_pct, input int lo,
                                                  input int cnt);
        lhwt_pkg::cmd_t c;
        int   roll;
        c.opcode      = lhwt_pkg::OP_TICK;
        c.entry_index = 8'($urandom_range(0, 255));
        c.flag_value  = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll >= tick_pct)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                c.opcode = 3'($urandom_range(5, 7));
            else if (roll < 35)
                c.opcode = lhwt_pkg::OP_HEARTBEAT;
            else if (roll < 55)
                c.opcode = lhwt_pkg::OP_SET_CONN;
            else if (roll < 75)
                c.opcode = lhwt_pkg::OP_QUERY;
            else
                c.opcode = lhwt_pkg::OP_LOAD_VLD;
            if (c.opcode == lhwt_pkg::OP_SET_CONN || c.opcode == lhwt_pkg::OP_LOAD_VLD)
                c.flag_value = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 75)
                c.entry_index = 8'((lo + $urandom_range(0, cnt - 1))
                                   % lhwt_pkg::LHWT_ENTRIES);
            else if (roll < 85)
                c.entry_index = 8'(DB_INDEX);
        end
        return c;
    endfunction

    task automatic run_phase(input logic [7:0] reload, input logic [7:0] limit,
                             input logic [3:0] period, input int lo, input int cnt,
                             input int n, input int tick_pct);
        logic [3:0] junk;
        int         k;
        wait_idle();
        junk = 4'($urandom_range(0, 15));
        write_reg(lhwt_pkg::REG_COUNTDOWN_RELOAD, reload);
        write_reg(lhwt_pkg::REG_MISS_LIMIT, limit);
        write_reg(lhwt_pkg::REG_BEACON_PERIOD, {junk, period});
        // bring up a window of links
        for (k = 0; k < cnt; k++)
        begin
            send_op(lhwt_pkg::OP_LOAD_VLD, (lo + k) % lhwt_pkg::LHWT_ENTRIES, 1'b1);
            send_op(lhwt_pkg::OP_SET_CONN, (lo + k) % lhwt_pkg::LHWT_ENTRIES, 1'b1);
            send_op(lhwt_pkg::OP_HEARTBEAT, (lo + k) % lhwt_pkg::LHWT_ENTRIES, 1'b0);
        end
        for (k = 0; k < n; k++)
            send_cmd(random_cmd(tick_pct, lo, cnt), 1'b0, '0);
    endtask

    function automatic dir_row_t typed_row(input logic [2:0] op, input logic [7:0] idx,
                                           input logic flag, input logic beacon,
                                           input logic [8:0] drops, input logic conn,
                                           input logic err);
        dir_row_t r;
        r.c     = '{opcode: op, entry_index: idx, flag_value: flag};
        r.typed = 1'b1;
        r.want  = '{send_beacon: beacon, dropped_count: drops, is_connected: conn,
                    index_error: err};
        return r;
    endfunction

    function automatic dir_row_t open_row(input logic [2:0] op, input logic [7:0] idx,
                                          input logic flag);
        dir_row_t r;
        r.c     = '{opcode: op, entry_index: idx, flag_value: flag};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    initial
    begin
        int i;
        shadow_cfg = '{countdown_reload: lhwt_pkg::RST_COUNTDOWN_RELOAD,
                       miss_limit: lhwt_pkg::RST_MISS_LIMIT,
                       beacon_period: lhwt_pkg::RST_BEACON_PERIOD};
        for (i = 0; i < lhwt_pkg::LHWT_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_conn[i]  = 1'b0;
            tbl_count[i] = lhwt_pkg::RST_COUNTDOWN_RELOAD;
            tbl_miss[i]  = '0;
        end
        beacon_cnt = '0;

        directed = '{
            typed_row(lhwt_pkg::OP_QUERY,     8'd0,   1'b0, 1'b0, 9'd0, 1'b0, 1'b1),
            typed_row(lhwt_pkg::OP_HEARTBEAT, 8'd0,   1'b1, 1'b0, 9'd0, 1'b0, 1'b1),
            typed_row(lhwt_pkg::OP_SET_CONN,  8'd0,   1'b1, 1'b0, 9'd0, 1'b0, 1'b1),
            typed_row(lhwt_pkg::OP_QUERY,     8'd255, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(OP_UNUSED_5,            8'd255, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(OP_UNUSED_6,            8'd0,   1'b0, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(OP_UNUSED_7,            8'd128, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_TICK,      8'd0,   1'b0, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_LOAD_VLD,  8'd0,   1'b1, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_LOAD_VLD,  8'd255, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_SET_CONN,  8'd0,   1'b1, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_SET_CONN,  8'd255, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_QUERY,     8'd0,   1'b0, 1'b0, 9'd0, 1'b1, 1'b0),
            typed_row(lhwt_pkg::OP_QUERY,     8'd255, 1'b1, 1'b0, 9'd0, 1'b1, 1'b0),
            typed_row(lhwt_pkg::OP_HEARTBEAT, 8'd255, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0),
            open_row (lhwt_pkg::OP_TICK,      8'd255, 1'b1),
            open_row (lhwt_pkg::OP_TICK,      8'd0,   1'b0),
            open_row (lhwt_pkg::OP_TICK,      8'd170, 1'b1),
            typed_row(lhwt_pkg::OP_TICK,      8'd85,  1'b0, 1'b1, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_LOAD_VLD,  8'd0,   1'b0, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_QUERY,     8'd0,   1'b1, 1'b0, 9'd0, 1'b0, 1'b1),
            typed_row(lhwt_pkg::OP_LOAD_VLD,  8'd255, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0),
            typed_row(lhwt_pkg::OP_QUERY,     8'd255, 1'b0, 1'b0, 9'd0, 1'b1, 1'b0),
            typed_row(lhwt_pkg::OP_SET_CONN,  8'd255, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
            send_cmd(directed[k].c, directed[k].typed, directed[k].want);

        // unmapped register index, must leave every setting as it was
        wait_idle();
        write_reg(REG_UNUSED, 8'hff);

        run_phase(8'd1,   8'd0,   4'd1,  0,   40, 120, 30);
        run_phase(8'd2,   8'd3,   4'd3,  100, 20, 150, 35);
        run_phase(8'd0,   8'd1,   4'd0,  200, 16, 80,  40);
        run_phase(8'd255, 8'd255, 4'd15, 240, 16, 60,  20);
        // long tick run: miss counts climb toward saturation
        run_phase(8'd1,   8'd255, 4'd15, 10,  10, 280, 90);
        repeat (3)
            run_phase(8'($urandom_range(1, 6)), 8'($urandom_range(0, 4)),
                      4'($urandom_range(0, 15)), $urandom_range(0, 255), 12, 80, 30);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== link_heartbeat_watchdog_table.f =====
hdl/lhwt_pkg.sv
hdl/lhwt_ram.sv
hdl/lhwt_cfg.sv
hdl/link_heartbeat_watchdog_table.sv
sim/tb.sv
